// ===== rtl/bsrd_pkg.sv =====
// ============================================================================
// bsrd_pkg - shared types and constants of the scanline RLE decoder
// Command format between parser and executor, configuration bundle, opcode
// byte values and line length helper.
// ============================================================================
`default_nettype none

package bsrd_pkg;

    // Largest line the decoder tracks, in bytes
    localparam int MAX_LINE_BYTES  = 256;
    localparam int LINE_CAP        = (MAX_LINE_BYTES < 256) ? MAX_LINE_BYTES : 256;

    // Default pattern store depth
    localparam int DEF_MAX_PATTERN = 8;

    // Command queue depth (power of two)
    localparam int CMDQ_DEPTH      = 4;

    // Configuration register indexes and reset values
    localparam logic [1:0]  CFG_IMAGE_WIDTH  = 2'd0;
    localparam logic [1:0]  CFG_PATTERN_SIZE = 2'd1;
    localparam logic [1:0]  CFG_INVERT_OUT   = 2'd2;
    localparam logic [11:0] RST_IMAGE_WIDTH  = 12'd640;
    localparam logic [3:0]  RST_PATTERN_SIZE = 4'd2;
    localparam logic        RST_INVERT_OUT   = 1'b1;

    // Opcode byte values
    localparam logic [7:0] OP_ESCAPE  = 8'h00;
    localparam logic [7:0] OP_LITERAL = 8'h80;
    localparam logic [7:0] FILL_SET   = 8'hff;
    localparam logic [7:0] FILL_CLEAR = 8'h00;

    typedef struct packed {
        logic [11:0] image_width;
        logic [3:0]  pattern_size;
        logic        invert_out;
    } t_cfg;

    typedef enum logic [0:0] {
        CMD_RUN,
        CMD_REPEAT
    } t_cmd_op;

    // CMD_RUN: optionally store data at idx, push data cnt times, then push
    // prem bytes from the pattern store, then close the opcode if done.
    // CMD_REPEAT: set the line repeat count to data and close the opcode.
    typedef struct packed {
        t_cmd_op     op;
        logic [7:0]  data;
        logic [7:0]  cnt;
        logic [11:0] prem;
        logic [3:0]  idx;
        logic [3:0]  k;
        logic        wr;
        logic        done;
    } t_cmd;

    // Line length in bytes from the pixel width, at least one, capped
    function automatic logic [8:0] calc_line_len(input logic [11:0] width);
        logic [12:0] sum;
        logic [9:0]  len;
        sum = {1'b0, width} + 13'd7;
        len = sum[12:3];
        if (len == 10'd0) begin
            len = 10'd1;
        end
        if (len > 10'(LINE_CAP)) begin
            len = 10'(LINE_CAP);
        end
        return len[8:0];
    endfunction

endpackage

`default_nettype wire

// ===== rtl/bsrd_front.sv =====
// ============================================================================
// bsrd_front - opcode parser
// Takes compressed bytes, tracks the escape/literal/pattern phases and turns
// each byte with a visible effect into one command for the executor.
// ============================================================================
`default_nettype none

module bsrd_front import bsrd_pkg::*; #(
    parameter int MAX_PATTERN = DEF_MAX_PATTERN
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_cfg       i_cfg,
    input  wire logic       i_valid,
    output logic            o_ready,
    input  wire logic [7:0] i_code_byte,
    input  wire logic       i_q_full,
    output logic            o_push,
    output t_cmd            o_cmd
);

    typedef enum logic [2:0] {
        F_IDLE,
        F_ESC,
        F_REP_FLAG,
        F_REP_COUNT,
        F_PAT_FILL,
        F_LIT_COUNT,
        F_LIT_DATA
    } t_fstate;

    t_fstate     r_phase, n_phase;
    logic [7:0]  r_run, n_run;
    logic [3:0]  r_pidx, n_pidx;

    logic        accept;
    logic [3:0]  k_eff;
    logic        pat_final;
    logic [7:0]  reps_m1;
    logic [11:0] pat_rest;

    assign o_ready = !i_q_full;
    assign accept  = i_valid && o_ready;

    // Effective pattern size: zero acts as one, clip to store depth
    always_comb begin
        if (i_cfg.pattern_size == 4'd0) begin
            k_eff = 4'd1;
        end else if ({1'b0, i_cfg.pattern_size} > 5'(MAX_PATTERN)) begin
            k_eff = 4'(MAX_PATTERN);
        end else begin
            k_eff = i_cfg.pattern_size;
        end
    end

    // Pattern bytes still to push after the first copy
    assign pat_final = ({1'b0, r_pidx} + 5'd1) >= {1'b0, k_eff};
    assign reps_m1   = (r_run == 8'd0) ? 8'd0 : r_run - 8'd1;
    assign pat_rest  = 12'(reps_m1) * 12'(k_eff);

    // Classify the incoming byte and build its command
    always_comb begin
        n_phase = r_phase;
        n_run   = r_run;
        n_pidx  = r_pidx;
        o_push  = 1'b0;
        o_cmd   = '{op: CMD_RUN, data: i_code_byte, cnt: 8'd1, prem: 12'd0,
                    idx: 4'd0, k: k_eff, wr: 1'b0, done: 1'b1};
        if (accept) begin
            case (r_phase)
                F_IDLE: begin
                    if (i_code_byte == OP_ESCAPE) begin
                        n_phase = F_ESC;
                    end else if (i_code_byte == OP_LITERAL) begin
                        n_phase = F_LIT_COUNT;
                    end else begin
                        o_push     = 1'b1;
                        o_cmd.data = i_code_byte[7] ? FILL_SET : FILL_CLEAR;
                        o_cmd.cnt  = {1'b0, i_code_byte[6:0]};
                    end
                end
                F_ESC: begin
                    if (i_code_byte == OP_ESCAPE) begin
                        n_phase = F_REP_FLAG;
                    end else begin
                        n_run   = i_code_byte;
                        n_pidx  = 4'd0;
                        n_phase = F_PAT_FILL;
                    end
                end
                F_REP_FLAG: begin
                    n_phase = F_REP_COUNT;
                end
                F_REP_COUNT: begin
                    o_push   = 1'b1;
                    o_cmd.op = CMD_REPEAT;
                    n_phase  = F_IDLE;
                end
                F_PAT_FILL: begin
                    o_push     = 1'b1;
                    o_cmd.wr   = 1'b1;
                    o_cmd.idx  = r_pidx;
                    o_cmd.done = pat_final;
                    if (pat_final) begin
                        o_cmd.prem = pat_rest;
                        n_pidx     = 4'd0;
                        n_phase    = F_IDLE;
                    end else begin
                        n_pidx = r_pidx + 4'd1;
                    end
                end
                F_LIT_COUNT: begin
                    n_run = i_code_byte;
                    if (i_code_byte == 8'd0) begin
                        o_push    = 1'b1;
                        o_cmd.cnt = 8'd0;
                        n_phase   = F_IDLE;
                    end else begin
                        n_phase = F_LIT_DATA;
                    end
                end
                F_LIT_DATA: begin
                    o_push     = 1'b1;
                    o_cmd.done = (r_run <= 8'd1);
                    if (r_run != 8'd0) begin
                        n_run = r_run - 8'd1;
                    end
                    if (r_run <= 8'd1) begin
                        n_phase = F_IDLE;
                    end
                end
                default: begin
                    n_phase = F_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= F_IDLE;
            r_run   <= 8'd0;
            r_pidx  <= 4'd0;
        end else begin
            r_phase <= n_phase;
            r_run   <= n_run;
            r_pidx  <= n_pidx;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/bsrd_cmdq.sv =====
// ============================================================================
// bsrd_cmdq - command queue
// Short first-in first-out buffer between parser and executor.
// ============================================================================
`default_nettype none

module bsrd_cmdq import bsrd_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_cmd i_cmd,
    input  wire logic i_pop,
    output logic      o_valid,
    output logic      o_full,
    output t_cmd      o_cmd
);

    localparam int PW = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;

    t_cmd            r_mem [CMDQ_DEPTH];
    logic [PW-1:0]   r_wr, n_wr;
    logic [PW-1:0]   r_rd, n_rd;
    logic [PW:0]     r_cnt, n_cnt;

    assign o_valid = (r_cnt != '0);
    assign o_full  = (r_cnt == (PW+1)'(CMDQ_DEPTH));
    assign o_cmd   = r_mem[r_rd];

    // Advance pointers and fill level
    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wr = (r_wr == PW'(CMDQ_DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (i_pop) begin
            n_rd = (r_rd == PW'(CMDQ_DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
            if (i_push) begin
                r_mem[r_wr] <= i_cmd;
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/bsrd_back.sv =====
// ============================================================================
// bsrd_back - run executor and word packer
// Runs queued commands one decoded byte per cycle while the output register is
// free, packs bytes into output words, closes lines and flags dropped bytes.
// ============================================================================
`default_nettype none

module bsrd_back import bsrd_pkg::*; #(
    parameter int MAX_PATTERN = DEF_MAX_PATTERN
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire t_cfg   i_cfg,
    input  wire logic   i_cmd_valid,
    input  wire t_cmd   i_cmd,
    output logic        o_cmd_pop,
    output logic        o_valid,
    input  wire logic   i_ready,
    output logic [63:0] o_pixel_word,
    output logic [3:0]  o_valid_bytes,
    output logic        o_line_end,
    output logic [7:0]  o_line_repeat,
    output logic        o_overrun,
    output logic        o_last_of_run
);

    localparam int IDXW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

    typedef enum logic [1:0] {
        B_IDLE,
        B_RUN,
        B_PAT,
        B_END
    } t_bstate;

    t_bstate     r_state, n_state;
    logic [7:0]  r_byte, n_byte;
    logic [7:0]  r_left, n_left;
    logic [11:0] r_prem, n_prem;
    logic [3:0]  r_j, n_j;
    logic [3:0]  r_k, n_k;
    logic        r_done, n_done;
    logic [8:0]  r_pos, n_pos;
    logic [8:0]  r_len, n_len;
    logic [63:0] r_word, n_word;
    logic [7:0]  r_rep, n_rep;
    logic        r_ovr, n_ovr;
    logic [7:0]  r_store [MAX_PATTERN];

    logic        r_o_valid, n_o_valid;
    logic [63:0] r_o_word, n_o_word;
    logic [3:0]  r_o_nb, n_o_nb;
    logic        r_o_end, n_o_end;
    logic [7:0]  r_o_rep, n_o_rep;
    logic        r_o_ovr, n_o_ovr;
    logic        r_o_last, n_o_last;

    logic        out_free;
    logic        step_push;
    logic        step_end;
    logic [7:0]  p_byte;
    logic [11:0] p_rest;
    logic        p_done;
    logic [8:0]  len_eff;
    logic [7:0]  bb;
    logic [8:0]  pos1;
    logic        more_end;
    logic        more_word;
    logic [8:0]  len_m1;

    assign out_free = !r_o_valid || i_ready;
    assign len_eff  = (r_pos == 9'd0) ? calc_line_len(i_cfg.image_width) : r_len;
    assign len_m1   = r_len - 9'd1;

    always_comb begin
        n_state   = r_state;
        n_byte    = r_byte;
        n_left    = r_left;
        n_prem    = r_prem;
        n_j       = r_j;
        n_k       = r_k;
        n_done    = r_done;
        n_pos     = r_pos;
        n_len     = r_len;
        n_word    = r_word;
        n_rep     = r_rep;
        n_ovr     = r_ovr;
        n_o_valid = r_o_valid;
        n_o_word  = r_o_word;
        n_o_nb    = r_o_nb;
        n_o_end   = r_o_end;
        n_o_rep   = r_o_rep;
        n_o_ovr   = r_o_ovr;
        n_o_last  = r_o_last;
        o_cmd_pop = 1'b0;
        step_push = 1'b0;
        step_end  = 1'b0;
        p_byte    = r_byte;
        p_rest    = 12'd0;
        p_done    = r_done;
        bb        = 8'd0;
        pos1      = r_pos;
        more_end  = 1'b0;
        more_word = 1'b0;

        // Drop the word once the sink takes it
        if (r_o_valid && i_ready) begin
            n_o_valid = 1'b0;
        end

        // Sequence the current command
        case (r_state)
            B_IDLE: begin
                if (i_cmd_valid) begin
                    o_cmd_pop = 1'b1;
                    n_byte    = i_cmd.data;
                    n_left    = i_cmd.cnt;
                    n_prem    = i_cmd.prem;
                    n_j       = 4'd0;
                    n_k       = i_cmd.k;
                    n_done    = i_cmd.done;
                    if (i_cmd.op == CMD_REPEAT) begin
                        n_rep   = i_cmd.data;
                        n_state = B_END;
                    end else if (i_cmd.cnt != 8'd0) begin
                        n_state = B_RUN;
                    end else if (i_cmd.done) begin
                        n_state = B_END;
                    end
                end
            end
            B_RUN: begin
                if (out_free) begin
                    step_push = 1'b1;
                    p_byte    = r_byte;
                    p_rest    = 12'(r_left - 8'd1) + r_prem;
                    p_done    = r_done;
                    n_left    = r_left - 8'd1;
                    if (r_left == 8'd1) begin
                        if (r_prem != 12'd0) begin
                            n_state = B_PAT;
                        end else if (r_done) begin
                            n_state = B_END;
                        end else begin
                            n_state = B_IDLE;
                        end
                    end
                end
            end
            B_PAT: begin
                if (out_free) begin
                    step_push = 1'b1;
                    p_byte    = r_store[r_j[IDXW-1:0]];
                    p_rest    = r_prem - 12'd1;
                    p_done    = 1'b1;
                    n_prem    = r_prem - 12'd1;
                    n_j       = (({1'b0, r_j} + 5'd1) >= {1'b0, r_k}) ? 4'd0 : r_j + 4'd1;
                    if (r_prem == 12'd1) begin
                        n_state = B_END;
                    end
                end
            end
            B_END: begin
                if (out_free) begin
                    step_end = 1'b1;
                    n_state  = B_IDLE;
                end
            end
            default: begin
                n_state = B_IDLE;
            end
        endcase

        // Place one decoded byte, or drop it past the line end
        if (step_push) begin
            if (r_pos == 9'd0) begin
                n_len = len_eff;
            end
            if (r_pos != 9'd0 && r_pos >= r_len) begin
                n_ovr = 1'b1;
            end else begin
                bb = i_cfg.invert_out ? ~p_byte : p_byte;
                for (int i = 0; i < 8; i++) begin
                    if (r_pos[2:0] == 3'(i)) begin
                        n_word[8*i +: 8] = bb;
                    end
                end
                pos1  = r_pos + 9'd1;
                n_pos = pos1;
                if (pos1 < len_eff && pos1[2:0] == 3'd0) begin
                    // Last word of this input byte unless a later one follows
                    more_end  = p_done &&
                                (({4'd0, pos1} + {1'b0, p_rest}) >= {4'd0, len_eff});
                    more_word = (p_rest >= 12'd8) &&
                                (({1'b0, pos1} + 10'd8) < {1'b0, len_eff});
                    n_o_valid = 1'b1;
                    n_o_word  = n_word;
                    n_o_nb    = 4'd8;
                    n_o_end   = 1'b0;
                    n_o_rep   = 8'd0;
                    n_o_ovr   = 1'b0;
                    n_o_last  = !more_end && !more_word;
                    n_word    = 64'd0;
                end
            end
        end

        // Close the opcode: send the finished line
        if (step_end) begin
            if (r_pos != 9'd0 && r_pos >= r_len) begin
                n_o_valid = 1'b1;
                n_o_word  = r_word;
                n_o_nb    = {1'b0, len_m1[2:0]} + 4'd1;
                n_o_end   = 1'b1;
                n_o_rep   = r_rep;
                n_o_ovr   = r_ovr;
                n_o_last  = 1'b1;
                n_pos     = 9'd0;
                n_word    = 64'd0;
                n_rep     = 8'd1;
                n_ovr     = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= B_IDLE;
            r_left    <= 8'd0;
            r_prem    <= 12'd0;
            r_j       <= 4'd0;
            r_done    <= 1'b0;
            r_pos     <= 9'd0;
            r_len     <= 9'd1;
            r_word    <= 64'd0;
            r_rep     <= 8'd1;
            r_ovr     <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_byte    <= n_byte;
            r_left    <= n_left;
            r_prem    <= n_prem;
            r_j       <= n_j;
            r_k       <= n_k;
            r_done    <= n_done;
            r_pos     <= n_pos;
            r_len     <= n_len;
            r_word    <= n_word;
            r_rep     <= n_rep;
            r_ovr     <= n_ovr;
            r_o_valid <= n_o_valid;
            r_o_word  <= n_o_word;
            r_o_nb    <= n_o_nb;
            r_o_end   <= n_o_end;
            r_o_rep   <= n_o_rep;
            r_o_ovr   <= n_o_ovr;
            r_o_last  <= n_o_last;
            // Capture pattern bytes as their commands start
            if (r_state == B_IDLE && i_cmd_valid && i_cmd.op == CMD_RUN && i_cmd.wr) begin
                r_store[i_cmd.idx[IDXW-1:0]] <= i_cmd.data;
            end
        end
    end

    assign o_valid       = r_o_valid;
    assign o_pixel_word  = r_o_word;
    assign o_valid_bytes = r_o_nb;
    assign o_line_end    = r_o_end;
    assign o_line_repeat = r_o_rep;
    assign o_overrun     = r_o_ovr;
    assign o_last_of_run = r_o_last;

endmodule

`default_nettype wire

// ===== rtl/bitmap_scanline_rle_decoder.sv =====
// ============================================================================
// bitmap_scanline_rle_decoder - monochrome scanline run-length decoder
// Top level: configuration registers, parser, command queue and executor.
// ============================================================================
// A parser takes one compressed byte per cycle while the four-entry command
// queue has room; escape bytes, pattern counts, repeat flags and nonzero
// literal counts only change its phase. The executor pops each command in
// its idle state, pushes every decoded byte (solid, literal or pattern,
// dropped bytes included) in its run or pattern state and closes an opcode
// in its end state. The executor is the rate limit; it also waits whenever
// the output word register is full and not taken. Decoded bytes leave
// packed eight to a word, first byte lowest; the word that ends a line
// carries the repeat count and the overrun flag. Configuration writes
// belong to idle periods only.
`default_nettype none

module bitmap_scanline_rle_decoder import bsrd_pkg::*; #(
    parameter int MAX_PATTERN = DEF_MAX_PATTERN
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_idx,
    input  wire logic [11:0] i_cfg_data,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [7:0]  i_code_byte,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [63:0]      o_pixel_word,
    output logic [3:0]       o_valid_bytes,
    output logic             o_line_end,
    output logic [7:0]       o_line_repeat,
    output logic             o_overrun,
    output logic             o_last_of_run
);

    t_cfg r_cfg;
    logic q_full;
    logic q_valid;
    logic q_push;
    logic q_pop;
    t_cmd q_in;
    t_cmd q_out;

    // Hold configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.image_width  <= RST_IMAGE_WIDTH;
            r_cfg.pattern_size <= RST_PATTERN_SIZE;
            r_cfg.invert_out   <= RST_INVERT_OUT;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_IMAGE_WIDTH:  r_cfg.image_width  <= i_cfg_data;
                CFG_PATTERN_SIZE: r_cfg.pattern_size <= i_cfg_data[3:0];
                CFG_INVERT_OUT:   r_cfg.invert_out   <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    bsrd_front #(
        .MAX_PATTERN (MAX_PATTERN)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_code_byte (i_code_byte),
        .i_q_full    (q_full),
        .o_push      (q_push),
        .o_cmd       (q_in)
    );

    bsrd_cmdq u_cmdq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (q_in),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_full  (q_full),
        .o_cmd   (q_out)
    );

    bsrd_back #(
        .MAX_PATTERN (MAX_PATTERN)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_cmd_valid   (q_valid),
        .i_cmd         (q_out),
        .o_cmd_pop     (q_pop),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_pixel_word  (o_pixel_word),
        .o_valid_bytes (o_valid_bytes),
        .o_line_end    (o_line_end),
        .o_line_repeat (o_line_repeat),
        .o_overrun     (o_overrun),
        .o_last_of_run (o_last_of_run)
    );

endmodule

`default_nettype wire

// ===== sim/bitmap_scanline_rle_decoder_tb.sv =====
// ============================================================================
// bitmap_scanline_rle_decoder_tb - self-checking bench for the RLE decoder
// Streams compressed code bytes through the valid/ready input, predicts every
// pixel word from a behavioral decoder kept inside the bench, and compares
// each word leaving the block field by field. Directed cases cover solid,
// literal, pattern and repeat opcodes at the extremes; random streams follow.
// ============================================================================
`timescale 1ns / 1ps

module bitmap_scanline_rle_decoder_tb;
    import bsrd_pkg::*;

    localparam int         CYCLE_LIMIT  = 1_000_000;
    // Longest silent executor stretch: a 255-fold pattern of 8 bytes
    localparam int         QUIET_CYCLES = 2200;
    localparam int         PAT_DEPTH    = DEF_MAX_PATTERN;
    localparam int         RANDOM_BYTES = 26;
    localparam logic [7:0] SOLID_SET    = 8'h80;
    localparam logic [7:0] RUN_MASK     = 8'h7f;
    localparam logic [7:0] PAD_BYTE     = 8'h01;

    typedef enum logic [2:0] {
        SCAN_OPCODE,
        SCAN_ESCAPE,
        SCAN_REP_FLAG,
        SCAN_REP_COUNT,
        SCAN_PATTERN,
        SCAN_LIT_COUNT,
        SCAN_LIT_DATA
    } t_scan_phase;

    typedef struct {
        logic [63:0] pixels;
        logic [3:0]  nbytes;
        logic        line_end;
        logic [7:0]  rep_cnt;
        logic        overrun;
        logic        last;
    } t_pix_word;

    // DUT ports
    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_cfg_we    = 1'b0;
    logic [1:0]  i_cfg_idx   = CFG_IMAGE_WIDTH;
    logic [11:0] i_cfg_data  = '0;
    logic        i_valid     = 1'b0;
    logic [7:0]  i_code_byte = '0;
    logic        i_ready     = 1'b0;
    logic        o_ready;
    logic        o_valid;
    logic [63:0] o_pixel_word;
    logic [3:0]  o_valid_bytes;
    logic        o_line_end;
    logic [7:0]  o_line_repeat;
    logic        o_overrun;
    logic        o_last_of_run;

    // Decoder prediction state
    logic [11:0] cfg_width  = RST_IMAGE_WIDTH;
    logic [3:0]  cfg_psize  = RST_PATTERN_SIZE;
    logic        cfg_invert = RST_INVERT_OUT;
    t_scan_phase scan_phase = SCAN_OPCODE;
    int          run_left   = 0;
    logic [7:0]  pat_store [PAT_DEPTH];
    int          pat_idx    = 0;
    int          line_pos   = 0;
    int          line_len   = 1;
    logic [63:0] word_acc   = '0;
    logic [7:0]  rep_count  = 8'd1;
    logic        ovr_seen   = 1'b0;

    t_pix_word   step_words    [$];
    t_pix_word   pending_words [$];

    // Bench control and statistics
    bit gap_en   = 1'b1;
    bit stall_en = 1'b1;
    int errors          = 0;
    int cycle_count     = 0;
    int n_bytes_in      = 0;
    int n_words_checked = 0;
    int n_settings      = 0;

    bitmap_scanline_rle_decoder i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_code_byte   (i_code_byte),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_pixel_word  (o_pixel_word),
        .o_valid_bytes (o_valid_bytes),
        .o_line_end    (o_line_end),
        .o_line_repeat (o_line_repeat),
        .o_overrun     (o_overrun),
        .o_last_of_run (o_last_of_run)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------------
    function automatic void add_word(input logic [63:0] pixels, input logic [3:0] nbytes,
                                     input logic line_end, input logic [7:0] rep_cnt,
                                     input logic overrun);
        t_pix_word w;
        w.pixels   = pixels;
        w.nbytes   = nbytes;
        w.line_end = line_end;
        w.rep_cnt  = rep_cnt;
        w.overrun  = overrun;
        w.last     = 1'b0;
        step_words.push_back(w);
    endfunction

    // Append one decoded byte to the current line, drop it past the line end
    function automatic void put_byte(input logic [7:0] b);
        int len;
        if (line_pos == 0) begin
            len = (int'(cfg_width) + 7) / 8;
            if (len == 0) len = 1;
            if (len > LINE_CAP) len = LINE_CAP;
            line_len = len;
        end
        if (line_pos > 0 && line_pos >= line_len) begin
            ovr_seen = 1'b1;
            return;
        end
        if (cfg_invert) b = ~b;
        word_acc[8 * (line_pos % 8) +: 8] = b;
        line_pos++;
        if (line_pos < line_len && (line_pos % 8) == 0) begin
            add_word(word_acc, 4'd8, 1'b0, 8'd0, 1'b0);
            word_acc = '0;
        end
    endfunction

    // End of an opcode: release the line word if the line is full
    function automatic void close_opcode();
        scan_phase = SCAN_OPCODE;
        if (line_pos > 0 && line_pos >= line_len) begin
            add_word(word_acc, 4'(((line_len - 1) % 8) + 1), 1'b1, rep_count, ovr_seen);
            line_pos  = 0;
            word_acc  = '0;
            rep_count = 8'd1;
            ovr_seen  = 1'b0;
        end
    endfunction

    function automatic int pattern_len();
        if (cfg_psize == 4'd0) return 1;
        if (int'(cfg_psize) > PAT_DEPTH) return PAT_DEPTH;
        return int'(cfg_psize);
    endfunction

    // Advance the decoder by one code byte and queue the words it yields
    function automatic void decode_byte(input logic [7:0] c);
        int k;
        int reps;
        step_words.delete();
        case (scan_phase)
            SCAN_OPCODE: begin
                if (c == OP_ESCAPE) begin
                    scan_phase = SCAN_ESCAPE;
                end else if (c == OP_LITERAL) begin
                    scan_phase = SCAN_LIT_COUNT;
                end else begin
                    repeat (int'(c & RUN_MASK)) put_byte(c[7] ? FILL_SET : FILL_CLEAR);
                    close_opcode();
                end
            end
            SCAN_ESCAPE: begin
                if (c == OP_ESCAPE) begin
                    scan_phase = SCAN_REP_FLAG;
                end else begin
                    run_left   = int'(c);
                    pat_idx    = 0;
                    scan_phase = SCAN_PATTERN;
                end
            end
            SCAN_REP_FLAG: begin
                scan_phase = SCAN_REP_COUNT;
            end
            SCAN_REP_COUNT: begin
                rep_count = c;
                close_opcode();
            end
            SCAN_PATTERN: begin
                k = pattern_len();
                if (pat_idx < PAT_DEPTH) pat_store[pat_idx] = c;
                put_byte(c);
                pat_idx++;
                if (pat_idx >= k) begin
                    reps = (run_left == 0) ? 1 : run_left;
                    for (int i = 1; i < reps; i++) begin
                        for (int j = 0; j < k; j++) put_byte(pat_store[j]);
                    end
                    pat_idx = 0;
                    close_opcode();
                end
            end
            SCAN_LIT_COUNT: begin
                run_left = int'(c);
                if (c == 8'd0) close_opcode();
                else scan_phase = SCAN_LIT_DATA;
            end
            SCAN_LIT_DATA: begin
                put_byte(c);
                if (run_left > 0) run_left--;
                if (run_left == 0) close_opcode();
            end
            default: begin
                scan_phase = SCAN_OPCODE;
            end
        endcase
        if (step_words.size() > 0) step_words[$].last = 1'b1;
        foreach (step_words[i]) pending_words.push_back(step_words[i]);
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    // Send one code byte; hold valid across back-to-back bytes
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = gap_en ? $urandom_range(0, 12) : 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_code_byte <= b;
        do @(posedge i_clk); while (!o_ready);
        n_bytes_in++;
        decode_byte(b);
    endtask

    // Write all three registers on consecutive edges
    task automatic set_config(input logic [11:0] width, input logic [3:0] psize,
                              input logic inv);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_IMAGE_WIDTH;
        i_cfg_data <= width;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_PATTERN_SIZE;
        i_cfg_data <= {8'd0, psize};
        @(posedge i_clk);
        i_cfg_idx  <= CFG_INVERT_OUT;
        i_cfg_data <= {11'd0, inv};
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        cfg_width  = width;
        cfg_psize  = psize;
        cfg_invert = inv;
        n_settings++;
    endtask

    // Bring the parser back to its opcode phase, fill the open line, then
    // hold the sender until every word is back and the executor is quiet
    task automatic close_phase();
        int left;
        while (scan_phase != SCAN_OPCODE) send_byte(PAD_BYTE);
        while (line_pos != 0) begin
            left = line_len - line_pos;
            send_byte(8'(left > 127 ? 127 : left));
        end
        i_valid <= 1'b0;
        while (pending_words.size() != 0) @(posedge i_clk);
        repeat (QUIET_CYCLES) @(posedge i_clk);
    endtask

    // One well-formed opcode with random content, or a little raw noise
    task automatic send_random_opcode();
        int         pick;
        int         n;
        logic [7:0] b;
        pick = $urandom_range(0, 99);
        if (pick < 30) begin
            n = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 127) : $urandom_range(1, 20);
            b = 8'(n);
            if ($urandom_range(0, 1) == 1) b = b | SOLID_SET;
            send_byte(b);
        end else if (pick < 50) begin
            n = $urandom_range(0, 12);
            send_byte(OP_LITERAL);
            send_byte(8'(n));
            repeat (n) send_byte(8'($urandom));
        end else if (pick < 75) begin
            n = ($urandom_range(0, 19) == 0) ? $urandom_range(1, 255) : $urandom_range(1, 12);
            send_byte(OP_ESCAPE);
            send_byte(8'(n));
            repeat (pattern_len()) send_byte(8'($urandom));
        end else if (pick < 87) begin
            send_byte(OP_ESCAPE);
            send_byte(OP_ESCAPE);
            send_byte(($urandom_range(0, 3) == 0) ? 8'($urandom) : FILL_SET);
            send_byte(8'($urandom));
        end else begin
            repeat ($urandom_range(1, 3)) send_byte(8'($urandom));
        end
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    // Reset settings: odd repeat flag with count zero, then a solid run that
    // overflows the 80-byte line
    task automatic test_reset_settings();
        send_byte(OP_ESCAPE);
        send_byte(OP_ESCAPE);
        send_byte(8'h3c);
        send_byte(8'h00);
        send_byte(8'hff);
        close_phase();
    endtask

    // Literals of zero and two bytes, a short clear run, no inversion
    task automatic test_literal();
        set_config(12'd64, 4'd1, 1'b0);
        send_byte(OP_LITERAL);
        send_byte(8'h00);
        send_byte(OP_LITERAL);
        send_byte(8'h02);
        send_byte(8'h00);
        send_byte(8'hff);
        send_byte(8'h05);
        close_phase();
    endtask

    // Widest line and largest pattern shown 255 times: 32 words from one byte
    task automatic test_long_pattern();
        set_config(12'd2048, 4'd8, 1'b1);
        send_byte(OP_ESCAPE);
        send_byte(8'hff);
        send_byte(8'h01);
        send_byte(8'h80);
        send_byte(8'h7f);
        send_byte(8'hfe);
        send_byte(8'h55);
        send_byte(8'haa);
        send_byte(8'h00);
        send_byte(8'hff);
        close_phase();
    endtask

    // One-pixel lines: every byte ends a line, extra bytes overrun
    task automatic test_short_line();
        set_config(12'd1, 4'd1, 1'b1);
        send_byte(8'h81);
        send_byte(OP_ESCAPE);
        send_byte(8'h01);
        send_byte(8'ha5);
        send_byte(8'h7f);
        close_phase();
    endtask

    // Random streams over several settings and idling mixes
    task automatic test_random_streams();
        logic [11:0] width;
        int          start;
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0:       width = 12'($urandom_range(1, 64));
                1:       width = 12'($urandom_range(65, 512));
                2:       width = 12'($urandom_range(1, 24));
                default: width = 12'($urandom_range(1, 2048));
            endcase
            gap_en   = (ph != 1);
            stall_en = (ph != 2);
            set_config(width, 4'($urandom_range(1, 8)), 1'($urandom_range(0, 1)));
            start = n_bytes_in;
            while (n_bytes_in - start < RANDOM_BYTES) send_random_opcode();
            close_phase();
        end
        gap_en   = 1'b1;
        stall_en = 1'b1;
    endtask

    // ------------------------------------------------------------------------
    // Output side: random stalls, and compare each accepted word
    // ------------------------------------------------------------------------
    initial begin : sink_drive
        int stall;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            stall = stall_en ? $urandom_range(0, 12) : 0;
            if (stall > 0) begin
                i_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (!(o_valid && i_ready));
        end
    end

    always @(posedge i_clk) begin
        t_pix_word w;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_words.size() == 0) begin
                $error("unexpected pixel word %h", o_pixel_word);
                errors++;
            end else begin
                w = pending_words.pop_front();
                n_words_checked++;
                if (o_pixel_word !== w.pixels) begin
                    $error("pixel_word: expected %h, got %h", w.pixels, o_pixel_word);
                    errors++;
                end
                if (o_valid_bytes !== w.nbytes) begin
                    $error("valid_bytes: expected %0d, got %0d", w.nbytes, o_valid_bytes);
                    errors++;
                end
                if (o_line_end !== w.line_end) begin
                    $error("line_end: expected %b, got %b", w.line_end, o_line_end);
                    errors++;
                end
                if (o_line_repeat !== w.rep_cnt) begin
                    $error("line_repeat: expected %0d, got %0d", w.rep_cnt, o_line_repeat);
                    errors++;
                end
                if (o_overrun !== w.overrun) begin
                    $error("overrun: expected %b, got %b", w.overrun, o_overrun);
                    errors++;
                end
                if (o_last_of_run !== w.last) begin
                    $error("last_of_run: expected %b, got %b", w.last, o_last_of_run);
                    errors++;
                end
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("bitmap_scanline_rle_decoder: mismatch");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_settings();
        test_literal();
        test_long_pattern();
        test_short_line();
        test_random_streams();

        $display("covered %0d code bytes and %0d pixel words over %0d register settings",
                 n_bytes_in, n_words_checked, n_settings);
        $display("solid, literal, pattern and line repeat opcodes with overrun and stalls");
        if (errors == 0 && pending_words.size() == 0) begin
            $display("bitmap_scanline_rle_decoder: match");
        end else begin
            $display("bitmap_scanline_rle_decoder: mismatch");
        end
        $finish;
    end

endmodule
